// File: src/tournament_branch_predictor_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the tournament predictor RTL.
// ----------------------------------------------------------------------------
`ifndef TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH
`define TOURNAMENT_BRANCH_PREDICTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TBP_ASSERT_NOW(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TBP_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// File: src/tbp_pkg.sv
// ----------------------------------------------------------------------------
// tbp_pkg
// Types, sizes and counter helpers for the tournament branch predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbp_pkg;

  localparam int INDEX_BITS  = 12;
  localparam int COUNT_WIDTH = 32;
  localparam int DEPTH       = 1 << INDEX_BITS;
  localparam int OUT_WIDTH   = 32;

  typedef logic [INDEX_BITS-1:0]  index_t;
  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam count_t COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // 2-bit counter encodings
  localparam logic [1:0] CTR_MIN = 2'd0;
  localparam logic [1:0] CTR_MAX = 2'd3;

  typedef struct packed {
    logic [31:0] branch_address;
    logic        taken;
  } branch_t;

  typedef struct packed {
    logic                 chosen_prediction;
    logic                 gshare_guess;
    logic                 bimodal_guess;
    logic [OUT_WIDTH-1:0] gshare_hits;
    logic [OUT_WIDTH-1:0] bimodal_hits;
    logic [OUT_WIDTH-1:0] branches_seen;
    logic [OUT_WIDTH-1:0] best_hits;
  } result_t;

  // chooser in upper half, bimodal in lower half of one entry
  typedef struct packed {
    logic [1:0] chooser;
    logic [1:0] bimodal;
  } bc_entry_t;

  function automatic logic [1:0] train(input logic [1:0] c, input logic up);
    logic [1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? CTR_MAX : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? CTR_MIN : c - 2'd1;
    end
    return r;
  endfunction

  function automatic count_t bump(input count_t n, input logic en);
    count_t r;
    r = (en && n != COUNT_MAX) ? n + count_t'(1) : n;
    return r;
  endfunction

endpackage

// File: src/tournament_branch_predictor.sv
// ----------------------------------------------------------------------------
// tournament_branch_predictor: gshare vs bimodal with per-address chooser.
// Flow: a branch beat goes through the registered table read, then the update
// stage, into the result register. Throughput: one branch per cycle while
// branch_stall is low; bound by the single read-modify-write pass through
// each table, with write-to-read forwarding for repeats. Reset: a clearing
// pass writes every table entry (one per cycle); branch_stall stays high until it finishes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "tournament_branch_predictor_macros.svh"

module tournament_branch_predictor (
  input  logic             clk,
  input  logic             rst,
  input  logic             branch_valid,
  output logic             branch_stall,
  input  tbp_pkg::branch_t branch,
  output logic             result_valid,
  input  logic             result_stall,
  output tbp_pkg::result_t result
);

  // --------------------------------------------------------------------------
  // Storage. gmem holds the gshare counters; bcmem holds the bimodal and
  // chooser counters, which share the address index.
  // --------------------------------------------------------------------------
  logic [1:0]         gmem  [tbp_pkg::DEPTH];
  tbp_pkg::bc_entry_t bcmem [tbp_pkg::DEPTH];

  // clearing pass after reset
  logic            clearing;
  tbp_pkg::index_t clr_idx;

  // global history, updated as each branch is accepted
  tbp_pkg::index_t hist;

  // update stage: holds the branch whose table entries are being read back
  logic               s1_valid;
  tbp_pkg::index_t    s1_bidx;
  tbp_pkg::index_t    s1_gidx;
  logic               s1_taken;
  logic [1:0]         g_rd;
  tbp_pkg::bc_entry_t bc_rd;

  // last write per table, forwarded when the next read hit the same entry
  logic               lw_valid;
  tbp_pkg::index_t    lw_gidx;
  tbp_pkg::index_t    lw_bidx;
  logic [1:0]         lw_g;
  tbp_pkg::bc_entry_t lw_bc;

  // running counts
  tbp_pkg::count_t gcnt;
  tbp_pkg::count_t bcnt;
  tbp_pkg::count_t ncnt;

  logic               accept;
  logic               s1_adv;
  logic               s1_fire;
  tbp_pkg::index_t    in_bidx;
  tbp_pkg::index_t    in_gidx;
  logic [1:0]         g_cur;
  tbp_pkg::bc_entry_t bc_cur;
  logic               gpred;
  logic               bpred;
  logic               cpred;
  logic [1:0]         g_new;
  tbp_pkg::bc_entry_t bc_new;
  tbp_pkg::count_t    gcnt_next;
  tbp_pkg::count_t    bcnt_next;
  tbp_pkg::count_t    ncnt_next;

  // write port selection: clearing pass or update stage
  logic               g_we;
  tbp_pkg::index_t    g_waddr;
  logic [1:0]         g_wdata;
  logic               bc_we;
  tbp_pkg::index_t    bc_waddr;
  tbp_pkg::bc_entry_t bc_wdata;

  // --------------------------------------------------------------------------
  // Handshake. The update stage moves on whenever the output register is
  // empty or being drained, so a result can sit while the next branch enters.
  // --------------------------------------------------------------------------
  assign s1_adv       = !result_valid || !result_stall;
  assign s1_fire      = s1_valid && s1_adv;
  assign branch_stall = clearing || (s1_valid && !s1_adv);
  assign accept       = branch_valid && !branch_stall;

  assign in_bidx = branch.branch_address[tbp_pkg::INDEX_BITS-1:0];
  assign in_gidx = in_bidx ^ hist;

  // --------------------------------------------------------------------------
  // Update logic. The write of the previous branch lands at the same edge as
  // this branch's read, so a matching index takes the forwarded value.
  // --------------------------------------------------------------------------
  always_comb begin
    g_cur  = (lw_valid && lw_gidx == s1_gidx) ? lw_g  : g_rd;
    bc_cur = (lw_valid && lw_bidx == s1_bidx) ? lw_bc : bc_rd;

    gpred = g_cur[1];
    bpred = bc_cur.bimodal[1];
    // chooser 0/1 -> gshare, 2/3 -> bimodal
    cpred = bc_cur.chooser[1] ? bpred : gpred;

    g_new          = tbp_pkg::train(g_cur, s1_taken);
    bc_new.bimodal = tbp_pkg::train(bc_cur.bimodal, s1_taken);
    bc_new.chooser = (gpred != bpred) ? tbp_pkg::train(bc_cur.chooser, gpred != s1_taken)
                                      : bc_cur.chooser;

    gcnt_next = tbp_pkg::bump(gcnt, gpred == s1_taken);
    bcnt_next = tbp_pkg::bump(bcnt, bpred == s1_taken);
    ncnt_next = tbp_pkg::bump(ncnt, 1'b1);
  end

  always_comb begin
    if (clearing) begin
      g_we             = 1'b1;
      g_waddr          = clr_idx;
      g_wdata          = tbp_pkg::CTR_MIN;
      bc_we            = 1'b1;
      bc_waddr         = clr_idx;
      bc_wdata.chooser = tbp_pkg::CTR_MAX;
      bc_wdata.bimodal = tbp_pkg::CTR_MIN;
    end else begin
      g_we     = s1_fire;
      g_waddr  = s1_gidx;
      g_wdata  = g_new;
      bc_we    = s1_fire;
      bc_waddr = s1_bidx;
      bc_wdata = bc_new;
    end
  end

  // --------------------------------------------------------------------------
  // Memories: at most one write and one registered read per cycle each.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (g_we) begin
      gmem[g_waddr] <= g_wdata;
    end
    if (accept) begin
      g_rd <= gmem[in_gidx];
    end
  end

  always_ff @(posedge clk) begin
    if (bc_we) begin
      bcmem[bc_waddr] <= bc_wdata;
    end
    if (accept) begin
      bc_rd <= bcmem[in_bidx];
    end
  end

  // --------------------------------------------------------------------------
  // Control and stage registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing     <= 1'b1;
      clr_idx      <= '0;
      hist         <= '0;
      s1_valid     <= 1'b0;
      lw_valid     <= 1'b0;
      result_valid <= 1'b0;
      gcnt         <= '0;
      bcnt         <= '0;
      ncnt         <= '0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + tbp_pkg::index_t'(1);
        if (&clr_idx) begin
          clearing <= 1'b0;
        end
      end

      if (accept) begin
        hist     <= {hist[tbp_pkg::INDEX_BITS-2:0], branch.taken};
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_fire) begin
        lw_valid <= 1'b1;
        gcnt     <= gcnt_next;
        bcnt     <= bcnt_next;
        ncnt     <= ncnt_next;
      end

      if (s1_adv) begin
        result_valid <= s1_valid;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bidx  <= in_bidx;
      s1_gidx  <= in_gidx;
      s1_taken <= branch.taken;
    end
    if (s1_fire) begin
      lw_gidx <= s1_gidx;
      lw_bidx <= s1_bidx;
      lw_g    <= g_new;
      lw_bc   <= bc_new;

      result.chosen_prediction <= cpred;
      result.gshare_guess      <= gpred;
      result.bimodal_guess     <= bpred;
      result.gshare_hits       <= tbp_pkg::OUT_WIDTH'(gcnt_next);
      result.bimodal_hits      <= tbp_pkg::OUT_WIDTH'(bcnt_next);
      result.branches_seen     <= tbp_pkg::OUT_WIDTH'(ncnt_next);
      // tie goes to bimodal
      result.best_hits         <= (gcnt_next > bcnt_next) ?
                                  tbp_pkg::OUT_WIDTH'(gcnt_next) :
                                  tbp_pkg::OUT_WIDTH'(bcnt_next);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `TBP_ASSERT_NOW(a_no_accept_clear, clk, rst, clearing, branch_stall, "branch taken during clear")
  `TBP_ASSERT_NEXT(a_fire_to_result, clk, rst, s1_fire, result_valid, "update lost its result")
  `TBP_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && !s1_adv, s1_valid && $stable(s1_bidx), "stage dropped")
  `TBP_ASSERT_NOW(a_count_order, clk, rst, 1'b1, gcnt <= ncnt && bcnt <= ncnt, "hits exceed branches")

endmodule
